// ----- src/mlbs_pkg.sv -----
// mlbs_pkg: shared types and constants of the multi-LED blink scheduler
// item structs, opcode and register index codes, status between the update logic and the top
// no dependencies
package mlbs_pkg;

  localparam int NUM_LEDS_DEFAULT  = 8;
  localparam int TIME_BITS_DEFAULT = 16;

  localparam logic [15:0] COUNT_FOREVER = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BLINK = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_ENABLED_MASK     = 2'd0,
    CFG_ACTIVE_HIGH_MASK = 2'd1,
    CFG_START_DELAY      = 2'd2,
    CFG_END_DELAY        = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         led_index;
    logic signed [15:0] blink_count;
    logic [15:0]        on_ticks;
    logic [15:0]        period_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic [7:0] busy_mask;
    logic       command_error;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic active;
    logic lit_wr;
    logic lit;
    logic err;
  } upd_status_t;

  // count, on, off, backup count, backup on, backup off, backup valid, remaining, should_on
  function automatic int entry_w(int time_bits);
    return 5 * time_bits + 34;
  endfunction

endpackage

// ----- src/mlbs_ram.sv -----
// mlbs_ram: per-LED state memory, one write port and one registered read port
// no dependencies
module mlbs_ram #(
  parameter int WIDTH  = 114,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mlbs_update.sv -----
// mlbs_update: read-modify-write logic for one LED state entry (tick, blink, stop)
// depends on mlbs_pkg
module mlbs_update #(
  parameter int TIME_BITS = mlbs_pkg::TIME_BITS_DEFAULT
) (
  input  logic [mlbs_pkg::entry_w(TIME_BITS)-1:0] q,
  output logic [mlbs_pkg::entry_w(TIME_BITS)-1:0] d,
  input  logic [1:0]                              opcode,
  input  logic                                    led_ok,
  input  logic                                    active,
  input  logic [15:0]                             blink_count,
  input  logic [15:0]                             on_ticks,
  input  logic [15:0]                             period_ticks,
  input  logic [TIME_BITS-1:0]                    start_delay,
  input  logic [TIME_BITS-1:0]                    end_delay,
  output mlbs_pkg::upd_status_t                   st
);

  localparam int TB     = TIME_BITS;
  localparam int O_SON  = 0;
  localparam int O_REM  = O_SON + 1;
  localparam int O_BV   = O_REM + TB;
  localparam int O_BOFF = O_BV + 1;
  localparam int O_BON  = O_BOFF + TB;
  localparam int O_BCNT = O_BON + TB;
  localparam int O_OFF  = O_BCNT + 16;
  localparam int O_ON   = O_OFF + TB;
  localparam int O_CNT  = O_ON + TB;

  logic [15:0]    c_cnt, c_bcnt, n_cnt, n_bcnt;
  logic [TB-1:0]  c_on, c_off, c_bon, c_boff, c_rem;
  logic [TB-1:0]  n_on, n_off, n_bon, n_boff, n_rem;
  logic           c_bv, c_son, n_bv, n_son;
  logic [TB-1:0]  rem_dec, on_t, off_t;
  logic [15:0]    off_raw;
  logic [31:0]    on_ext, off_ext;
  logic           c_pos, c_forever;

  assign c_son  = q[O_SON];
  assign c_rem  = q[O_REM +: TB];
  assign c_bv   = q[O_BV];
  assign c_boff = q[O_BOFF +: TB];
  assign c_bon  = q[O_BON +: TB];
  assign c_bcnt = q[O_BCNT +: 16];
  assign c_off  = q[O_OFF +: TB];
  assign c_on   = q[O_ON +: TB];
  assign c_cnt  = q[O_CNT +: 16];

  assign d = {n_cnt, n_on, n_off, n_bcnt, n_bon, n_boff, n_bv, n_rem, n_son};

  assign c_pos     = !c_cnt[15] && (c_cnt != 16'd0);
  assign c_forever = (c_cnt == mlbs_pkg::COUNT_FOREVER);
  assign rem_dec   = (c_rem != '0) ? c_rem - TB'(1) : '0;

  assign off_raw = period_ticks - on_ticks;
  assign on_ext  = {16'd0, on_ticks};
  assign off_ext = {16'd0, off_raw};
  assign on_t    = on_ext[TB-1:0];
  assign off_t   = off_ext[TB-1:0];

  always_comb begin
    n_cnt     = c_cnt;
    n_on      = c_on;
    n_off     = c_off;
    n_bcnt    = c_bcnt;
    n_bon     = c_bon;
    n_boff    = c_boff;
    n_bv      = c_bv;
    n_rem     = c_rem;
    n_son     = c_son;
    st        = '0;
    st.active = active;
    case (opcode)
      mlbs_pkg::OP_TICK: begin
        if (active) begin
          st.wr_en = 1'b1;
          n_rem    = rem_dec;
          if (rem_dec == '0) begin
            if (c_son) begin
              if (c_pos || c_forever) begin
                st.lit_wr = 1'b1;
                st.lit    = 1'b1;
                n_son     = 1'b0;
                n_rem     = c_on;
              end else if (c_bv) begin
                n_cnt  = c_bcnt;
                n_on   = c_bon;
                n_off  = c_boff;
                n_bcnt = '0;
                n_bon  = '0;
                n_boff = '0;
                n_bv   = 1'b0;
                n_rem  = (c_bcnt == mlbs_pkg::COUNT_FOREVER) ? end_delay : '0;
              end else begin
                st.active = 1'b0;
              end
            end else begin
              st.lit_wr = 1'b1;
              st.lit    = 1'b0;
              n_son     = 1'b1;
              n_rem     = c_off;
              if (c_pos) begin
                n_cnt = c_cnt - 16'd1;
              end
            end
          end
        end
      end
      mlbs_pkg::OP_STOP: begin
        if (!led_ok) begin
          st.err = 1'b1;
        end else begin
          st.wr_en  = 1'b1;
          st.lit_wr = 1'b1;
          st.lit    = 1'b0;
          st.active = 1'b0;
          n_bcnt    = '0;
          n_bon     = '0;
          n_boff    = '0;
          n_bv      = 1'b0;
        end
      end
      mlbs_pkg::OP_BLINK: begin
        if (!led_ok || (on_ticks > period_ticks)) begin
          st.err = 1'b1;
        end else begin
          st.wr_en  = 1'b1;
          st.active = 1'b1;
          if (active && c_forever) begin
            n_bcnt    = c_cnt;
            n_bon     = c_on;
            n_boff    = c_off;
            n_bv      = 1'b1;
            st.lit_wr = 1'b1;
            st.lit    = 1'b0;
            n_cnt     = blink_count;
            n_on      = on_t;
            n_off     = off_t;
            n_rem     = start_delay;
            n_son     = 1'b1;
          end else if (active) begin
            n_bcnt = blink_count;
            n_bon  = on_t;
            n_boff = off_t;
            n_bv   = 1'b1;
          end else begin
            n_cnt  = blink_count;
            n_on   = on_t;
            n_off  = off_t;
            n_rem  = '0;
            n_son  = 1'b1;
            n_bcnt = '0;
            n_bon  = '0;
            n_boff = '0;
            n_bv   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/multi_led_blink_scheduler.sv -----
// multi_led_blink_scheduler: top level, sequencer over the per-LED state memory
// depends on mlbs_pkg, mlbs_ram, mlbs_update
//
// Usage: an item (tick, blink or stop command) is taken on start while busy is low.
// Each item gives one result on the result port, marked by a one-cycle done strobe;
// the receiver cannot stall, so the result must be taken in that cycle.
// Per-LED patterns live in a state memory with a registered read; the lit and active
// bits of each LED sit in flip-flops so the result shows all LEDs at once.
// A tick walks the memory one LED entry per cycle, reading the next entry while the
// previous one is written back; the strobe comes as the last entry is written back.
// A blink or stop reads and writes back one entry (S_CMD_RD, S_CMD_WR), then strobes.
// busy is high while a tick or a command is in progress, and is
// low again in the strobe cycle, where the next item can be taken.
// Registers are written through the write port whenever write_enable is high.
// Synchronous reset clears all LEDs to dark and idle and restores register defaults;
// the memory needs no clearing, an idle LED's entry is never used before it is written.
module multi_led_blink_scheduler #(
  parameter int NUM_LEDS  = mlbs_pkg::NUM_LEDS_DEFAULT,
  parameter int TIME_BITS = mlbs_pkg::TIME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mlbs_pkg::in_item_t  item,
  output logic                done,
  output mlbs_pkg::out_item_t result,
  input  logic                write_enable,
  input  logic [1:0]          write_index,
  input  logic [15:0]         write_data
);

  localparam int ENT_W = mlbs_pkg::entry_w(TIME_BITS);
  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CW    = $clog2(NUM_LEDS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_CMD_RD,
    S_CMD_WR
  } state_t;

  state_t                state;
  mlbs_pkg::in_item_t    item_q;
  logic [CW-1:0]         k;
  logic [NUM_LEDS-1:0]   pin;
  logic [NUM_LEDS-1:0]   act;
  logic                  err;
  logic [7:0]            enabled_mask;
  logic [7:0]            active_high_mask;
  logic [15:0]           start_delay_ticks;
  logic [15:0]           end_delay_ticks;

  logic [4:0]            idx_ext;
  logic [IDX_W-1:0]      idx_sel, proc_idx, upd_idx, raddr;
  logic                  led_ok, upd_active, we;
  logic [ENT_W-1:0]      rdata, wdata;
  logic [31:0]           sd_ext, ed_ext;
  mlbs_pkg::upd_status_t st;

  assign idx_ext  = {2'b00, item_q.led_index};
  assign idx_sel  = idx_ext[IDX_W-1:0];
  assign proc_idx = IDX_W'(k - CW'(1));
  assign led_ok   = (32'(item_q.led_index) < NUM_LEDS) && enabled_mask[item_q.led_index];
  assign upd_idx  = (state == S_TICK) ? proc_idx : idx_sel;
  assign upd_active = act[upd_idx] & ((state == S_TICK) ? (k != '0) : led_ok);
  assign raddr    = (state == S_TICK) ? k[IDX_W-1:0] : idx_sel;
  assign we       = st.wr_en && (((state == S_TICK) && (k != '0)) || (state == S_CMD_WR));
  assign sd_ext   = {16'd0, start_delay_ticks};
  assign ed_ext   = {16'd0, end_delay_ticks};
  assign busy     = (state != S_IDLE);

  mlbs_ram #(
    .WIDTH  (ENT_W),
    .DEPTH  (NUM_LEDS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (upd_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mlbs_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .q            (rdata),
    .d            (wdata),
    .opcode       (item_q.opcode),
    .led_ok       (led_ok),
    .active       (upd_active),
    .blink_count  (item_q.blink_count),
    .on_ticks     (item_q.on_ticks),
    .period_ticks (item_q.period_ticks),
    .start_delay  (sd_ext[TIME_BITS-1:0]),
    .end_delay    (ed_ext[TIME_BITS-1:0]),
    .st           (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      k                 <= '0;
      pin               <= '0;
      act               <= '0;
      done              <= 1'b0;
      err               <= 1'b0;
      enabled_mask      <= 8'h00;
      active_high_mask  <= 8'hFF;
      start_delay_ticks <= 16'd0;
      end_delay_ticks   <= 16'd0;
    end else begin
      if (write_enable) begin
        case (write_index)
          mlbs_pkg::CFG_ENABLED_MASK:     enabled_mask      <= write_data[7:0];
          mlbs_pkg::CFG_ACTIVE_HIGH_MASK: active_high_mask  <= write_data[7:0];
          mlbs_pkg::CFG_START_DELAY:      start_delay_ticks <= write_data;
          mlbs_pkg::CFG_END_DELAY:        end_delay_ticks   <= write_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            item_q <= item;
            k      <= '0;
            state  <= (item.opcode == mlbs_pkg::OP_TICK) ? S_TICK : S_CMD_RD;
          end
        end
        S_TICK: begin
          if ((k != '0) && st.wr_en) begin
            act[upd_idx] <= st.active;
            if (st.lit_wr) begin
              pin[upd_idx] <= st.lit;
            end
          end
          k <= k + CW'(1);
          if (k == CW'(NUM_LEDS)) begin
            state <= S_IDLE;
            done  <= 1'b1;
            err   <= 1'b0;
          end else begin
            done  <= 1'b0;
          end
        end
        S_CMD_RD: begin
          done  <= 1'b0;
          state <= S_CMD_WR;
        end
        S_CMD_WR: begin
          if (st.wr_en) begin
            act[upd_idx] <= st.active;
            if (st.lit_wr) begin
              pin[upd_idx] <= st.lit;
            end
          end
          err   <= st.err;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_out
    if (i < NUM_LEDS) begin : g_led
      assign result.pin_levels[i] = (pin[i] == active_high_mask[i]);
      assign result.busy_mask[i]  = act[i];
    end else begin : g_none
      assign result.pin_levels[i] = 1'b0;
      assign result.busy_mask[i]  = 1'b0;
    end
  end

  assign result.command_error = err;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for multi_led_blink_scheduler, a directed table then random
// tick, blink, stop and no-op items with register changes between phases, checked by an led model
// depends on mlbs_pkg and the multi_led_blink_scheduler rtl
module testbench;

  localparam int LEDS = 8;
  localparam int TICK_CYCLES = LEDS + 1;
  localparam int SETTLE = LEDS + 4;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NO_IDLE_PHASE = 4;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    mlbs_pkg::in_item_t   cmd;
    mlbs_pkg::cfg_index_t reg_idx;
    logic [15:0]          reg_val;
    bit                   typed;
    mlbs_pkg::out_item_t  want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  mlbs_pkg::in_item_t  item;
  logic                done;
  mlbs_pkg::out_item_t result;
  logic                write_enable;
  logic [1:0]          write_index;
  logic [15:0]         write_data;

  // led model state
  logic [7:0]  en_mask;
  logic [7:0]  hi_mask;
  logic [15:0] start_dly;
  logic [15:0] end_dly;
  logic [15:0] cnt_left [LEDS];
  logic [15:0] on_len [LEDS];
  logic [15:0] off_len [LEDS];
  logic [15:0] bk_cnt [LEDS];
  logic [15:0] bk_on [LEDS];
  logic [15:0] bk_off [LEDS];
  logic [16:0] remain [LEDS];
  logic [7:0]  bk_valid;
  logic [7:0]  led_active;
  logic [7:0]  want_on;
  logic [7:0]  lit;

  mlbs_pkg::out_item_t outputs_due [$];
  mlbs_pkg::out_item_t due_now;
  int                  mismatches = 0;

  multi_led_blink_scheduler u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .done         (done),
    .result       (result),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("** multi_led_blink_scheduler: FAILED **");
    $finish;
  end

  function automatic bit counting(input logic [15:0] c);
    return c >= 16'd1 && c <= 16'h7FFF;
  endfunction

  function automatic void load_pattern(input int n, input mlbs_pkg::in_item_t it,
                                       input logic [15:0] dly);
    cnt_left[n] = it.blink_count;
    on_len[n] = it.on_ticks;
    off_len[n] = it.period_ticks - it.on_ticks;
    remain[n] = {1'b0, dly};
    led_active[n] = 1'b1;
    want_on[n] = 1'b1;
  endfunction

  function automatic void clear_leds();
    en_mask = 8'h00;
    hi_mask = 8'hFF;
    start_dly = '0;
    end_dly = '0;
    for (int i = 0; i < LEDS; i++) begin
      cnt_left[i] = '0;
      on_len[i] = '0;
      off_len[i] = '0;
      bk_cnt[i] = '0;
      bk_on[i] = '0;
      bk_off[i] = '0;
      remain[i] = '0;
    end
    bk_valid = '0;
    led_active = '0;
    want_on = '0;
    lit = '0;
  endfunction

  function automatic mlbs_pkg::out_item_t advance_leds(input mlbs_pkg::in_item_t it);
    mlbs_pkg::out_item_t r;
    logic [15:0]         c;
    int                  n;
    r = '0;
    n = it.led_index;
    case (it.opcode)
      mlbs_pkg::OP_TICK: begin
        for (int i = 0; i < LEDS; i++) begin
          c = cnt_left[i];
          if (led_active[i]) begin
            if (remain[i] != 0) remain[i] = remain[i] - 1'b1;
            if (remain[i] == 0) begin
              if (want_on[i]) begin
                if (counting(c) || c == mlbs_pkg::COUNT_FOREVER) begin
                  lit[i] = 1'b1;
                  want_on[i] = 1'b0;
                  remain[i] = {1'b0, on_len[i]};
                end else if (bk_valid[i]) begin
                  cnt_left[i] = bk_cnt[i];
                  on_len[i] = bk_on[i];
                  off_len[i] = bk_off[i];
                  bk_cnt[i] = '0;
                  bk_on[i] = '0;
                  bk_off[i] = '0;
                  bk_valid[i] = 1'b0;
                  remain[i] = (cnt_left[i] == mlbs_pkg::COUNT_FOREVER) ?
                              {1'b0, end_dly} : '0;
                end else begin
                  led_active[i] = 1'b0;
                end
              end else begin
                lit[i] = 1'b0;
                want_on[i] = 1'b1;
                remain[i] = {1'b0, off_len[i]};
                if (counting(c)) cnt_left[i] = c - 1'b1;
              end
            end
          end
        end
      end
      mlbs_pkg::OP_BLINK, mlbs_pkg::OP_STOP: begin
        if (!en_mask[n]) begin
          r.command_error = 1'b1;
        end else if (it.opcode == mlbs_pkg::OP_STOP) begin
          lit[n] = 1'b0;
          bk_cnt[n] = '0;
          bk_on[n] = '0;
          bk_off[n] = '0;
          bk_valid[n] = 1'b0;
          led_active[n] = 1'b0;
        end else if (it.on_ticks > it.period_ticks) begin
          r.command_error = 1'b1;
        end else if (led_active[n] && cnt_left[n] == mlbs_pkg::COUNT_FOREVER) begin
          // endless pattern goes to the backup, new one after the start delay
          bk_cnt[n] = cnt_left[n];
          bk_on[n] = on_len[n];
          bk_off[n] = off_len[n];
          bk_valid[n] = 1'b1;
          lit[n] = 1'b0;
          load_pattern(n, it, start_dly);
        end else if (led_active[n]) begin
          bk_cnt[n] = it.blink_count;
          bk_on[n] = it.on_ticks;
          bk_off[n] = it.period_ticks - it.on_ticks;
          bk_valid[n] = 1'b1;
        end else begin
          load_pattern(n, it, '0);
        end
      end
      default: begin
      end
    endcase
    r.pin_levels = ~(lit ^ hi_mask);
    r.busy_mask = led_active;
    return r;
  endfunction

  function automatic row_t item_row(input mlbs_pkg::opcode_t op, input int led, input int cnt,
                                    input int on, input int per);
    row_t r;
    r.kind = ROW_ITEM;
    r.cmd.opcode = op;
    r.cmd.led_index = 3'(led);
    r.cmd.blink_count = 16'(cnt);
    r.cmd.on_ticks = 16'(on);
    r.cmd.period_ticks = 16'(per);
    r.reg_idx = mlbs_pkg::CFG_ENABLED_MASK;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input mlbs_pkg::opcode_t op, input int led, input int cnt,
                                     input int on, input int per, input logic [7:0] levels,
                                     input logic [7:0] active, input logic err);
    row_t r;
    r = item_row(op, led, cnt, on, per);
    r.typed = 1'b1;
    r.want.pin_levels = levels;
    r.want.busy_mask = active;
    r.want.command_error = err;
    return r;
  endfunction

  function automatic row_t reg_row(input mlbs_pkg::cfg_index_t idx, input logic [15:0] val);
    row_t r;
    r = item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic mlbs_pkg::in_item_t random_item();
    mlbs_pkg::in_item_t it;
    int                 pick;
    pick = $urandom_range(0, 99);
    it.led_index = 3'($urandom_range(0, LEDS - 1));
    it.blink_count = 16'($urandom_range(0, 5) - 1);
    it.on_ticks = 16'($urandom_range(0, 4));
    it.period_ticks = it.on_ticks + 16'($urandom_range(0, 4));
    if (pick < 48) begin
      it.opcode = mlbs_pkg::OP_TICK;
    end else if (pick < 84) begin
      it.opcode = mlbs_pkg::OP_BLINK;
      // pulse longer than the period
      if (pick >= 80) it.on_ticks = it.period_ticks + 16'($urandom_range(1, 3));
    end else if (pick < 92) begin
      it.opcode = mlbs_pkg::OP_STOP;
    end else if (pick < 94) begin
      it.opcode = mlbs_pkg::OP_NONE;
    end else begin
      it.opcode = (pick < 97) ? mlbs_pkg::OP_BLINK : mlbs_pkg::OP_TICK;
      it.blink_count = 16'($urandom);
      it.on_ticks = 16'($urandom);
      it.period_ticks = 16'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input mlbs_pkg::in_item_t it, input bit typed,
                           input mlbs_pkg::out_item_t want);
    mlbs_pkg::out_item_t predicted;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = advance_leds(it);
    outputs_due.push_back(typed ? want : predicted);
  endtask

  task automatic idle_gap(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, TICK_CYCLES + 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (outputs_due.size() != 0 && waited < 64) begin
      @(posedge clk);
      waited++;
    end
    if (outputs_due.size() != 0) begin
      $error("%0d results never arrived", outputs_due.size());
      mismatches++;
      outputs_due.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input mlbs_pkg::cfg_index_t idx, input logic [15:0] val);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
    case (idx)
      mlbs_pkg::CFG_ENABLED_MASK:     en_mask = val[7:0];
      mlbs_pkg::CFG_ACTIVE_HIGH_MASK: hi_mask = val[7:0];
      mlbs_pkg::CFG_START_DELAY:      start_dly = val;
      mlbs_pkg::CFG_END_DELAY:        end_dly = val;
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (outputs_due.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        due_now = outputs_due.pop_front();
        if (result.pin_levels !== due_now.pin_levels) begin
          $error("pin_levels: expected %h, got %h", due_now.pin_levels, result.pin_levels);
          mismatches++;
        end
        if (result.busy_mask !== due_now.busy_mask) begin
          $error("busy_mask: expected %h, got %h", due_now.busy_mask, result.busy_mask);
          mismatches++;
        end
        if (result.command_error !== due_now.command_error) begin
          $error("command_error: expected %b, got %b", due_now.command_error,
                 result.command_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t               steps [$];
    mlbs_pkg::in_item_t it;
    int                 phase;
    int                 sent;
    logic [7:0]         en_v;
    logic [7:0]         ah_v;
    logic [15:0]        sd_v;
    logic [15:0]        ed_v;

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    write_enable <= 1'b0;
    write_index <= mlbs_pkg::CFG_ENABLED_MASK;
    write_data <= '0;
    clear_leds();

    // register defaults: nothing enabled, all leds dark
    steps.push_back(typed_row(mlbs_pkg::OP_TICK, 7, -1, 16'hFFFF, 16'hFFFF,
                              8'h00, 8'h00, 1'b0));
    steps.push_back(typed_row(mlbs_pkg::OP_BLINK, 0, 1, 1, 2, 8'h00, 8'h00, 1'b1));
    steps.push_back(typed_row(mlbs_pkg::OP_STOP, 7, 0, 0, 0, 8'h00, 8'h00, 1'b1));
    steps.push_back(typed_row(mlbs_pkg::OP_NONE, 7, -1, 16'hFFFF, 16'hFFFF,
                              8'h00, 8'h00, 1'b0));
    steps.push_back(reg_row(mlbs_pkg::CFG_ENABLED_MASK, 16'h00FF));
    steps.push_back(reg_row(mlbs_pkg::CFG_ACTIVE_HIGH_MASK, 16'h00A5));
    steps.push_back(reg_row(mlbs_pkg::CFG_START_DELAY, 16'd2));
    steps.push_back(reg_row(mlbs_pkg::CFG_END_DELAY, 16'd1));
    steps.push_back(typed_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0, 8'h5A, 8'h00, 1'b0));
    steps.push_back(typed_row(mlbs_pkg::OP_BLINK, 2, 1, 5, 4, 8'h5A, 8'h00, 1'b1));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 0, 2, 1, 3));
    // finite pattern running: zero on time goes to the backup
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 0, 1, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 1, -1, 2, 4));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 3, -32768, 16'hFFFF, 16'hFFFF));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 4, 32767, 0, 16'hFFFF));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 7, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    // interrupts the endless pattern on led 1
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 1, 3, 1, 1));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(reg_row(mlbs_pkg::CFG_ENABLED_MASK, 16'h000F));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 5, 1, 1, 1));
    steps.push_back(item_row(mlbs_pkg::OP_STOP, 1, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_BLINK, 1, -1, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_STOP, 3, 0, 0, 0));
    steps.push_back(item_row(mlbs_pkg::OP_TICK, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[n]) begin
      if (steps[n].kind == ROW_REG) begin
        drain();
        write_reg(steps[n].reg_idx, steps[n].reg_val);
      end else begin
        send_item(steps[n].cmd, steps[n].typed, steps[n].want);
        idle_gap(1'b0);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          en_v = 8'hFF;
          ah_v = 8'hFF;
          sd_v = 16'h0000;
          ed_v = 16'h0000;
        end
        1: begin
          en_v = 8'hFF;
          ah_v = 8'h00;
          sd_v = 16'hFFFF;
          ed_v = 16'hFFFF;
        end
        2: begin
          // commands all refused, running patterns carry on
          en_v = 8'h00;
          ah_v = 8'($urandom);
          sd_v = 16'($urandom_range(0, 3));
          ed_v = 16'($urandom_range(0, 3));
        end
        default: begin
          en_v = ($urandom_range(0, 99) < 60) ? 8'hFF : 8'($urandom);
          ah_v = 8'($urandom);
          sd_v = 16'($urandom_range(0, 3));
          ed_v = 16'($urandom_range(0, 3));
        end
      endcase
      drain();
      write_reg(mlbs_pkg::CFG_ENABLED_MASK, {8'h00, en_v});
      write_reg(mlbs_pkg::CFG_ACTIVE_HIGH_MASK, {8'h00, ah_v});
      write_reg(mlbs_pkg::CFG_START_DELAY, sd_v);
      write_reg(mlbs_pkg::CFG_END_DELAY, ed_v);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        if (it.opcode != mlbs_pkg::OP_NONE) sent++;
        idle_gap(phase == NO_IDLE_PHASE);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** multi_led_blink_scheduler: PASSED **");
    end else begin
      $display("** multi_led_blink_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
